/* src/jsd_pkg.sv */
// ----------------------------------------------------------------------------
// jsd_pkg: shared types and constants of the joystick to servo duty mapper
// Angle limits, servo timing, register indexes and the state machine codes.
// ----------------------------------------------------------------------------
package jsd_pkg;

    // angle representation
    localparam int ANGLE_BITS = 8;
    localparam int LUT_DEPTH  = 2 ** ANGLE_BITS;

    localparam logic [ANGLE_BITS-1:0] ANGLE_LOW  = ANGLE_BITS'(70);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MID  = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] ANGLE_HIGH = ANGLE_BITS'(110);

    // both half ranges span the same number of degrees
    localparam int ANGLE_STEP = int'(ANGLE_HIGH) - int'(ANGLE_MID);
    localparam int QUOT_BITS  = $clog2(ANGLE_STEP + 1);
    localparam int STEP_BITS  = $clog2(QUOT_BITS);

    // servo pulse timing
    localparam int ANGLE_FULL   = 180;
    localparam int PULSE_MIN_US = 500;
    localparam int PULSE_MAX_US = 2500;
    localparam int PERIOD_US    = 20000;

    // smoothing weight is one over this
    localparam int ALPHA_DIV = 10;

    localparam int DEAD_BAND_RESET = 50;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_X_MIN,
        REG_X_CENTER,
        REG_X_MAX,
        REG_Y_MIN,
        REG_Y_CENTER,
        REG_Y_MAX,
        REG_DEAD_BAND
    } cfg_reg_t;

    // axis select
    localparam logic AXIS_HORIZ = 1'b0;
    localparam logic AXIS_VERT  = 1'b1;

    // front end sequencer
    typedef enum logic [1:0] {
        EMA_IDLE,
        EMA_MUL_SAMPLE,
        EMA_MUL_AVG,
        EMA_PUSH
    } ema_state_t;

    // back end sequencer
    typedef enum logic [2:0] {
        MAP_IDLE,
        MAP_CLASSIFY,
        MAP_PREP,
        MAP_DIVIDE,
        MAP_DONE
    } map_state_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* src/jsd_sample_if.sv */
// ----------------------------------------------------------------------------
// jsd_sample_if: input channel carrying one raw sample per axis
// Valid/ready handshake, one transaction per sample pair.
// ----------------------------------------------------------------------------
interface jsd_sample_if #(
    parameter int SAMPLE_BITS = 12
) ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_horiz;
    logic [SAMPLE_BITS-1:0] sample_vert;

    modport source (
        output valid,
        output sample_horiz,
        output sample_vert,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_horiz,
        input  sample_vert,
        output ready
    );

endinterface

/* src/jsd_duty_if.sv */
// ----------------------------------------------------------------------------
// jsd_duty_if: output channel carrying servo duty and angle per axis
// Valid/ready handshake, one transaction per result.
// ----------------------------------------------------------------------------
interface jsd_duty_if
    import jsd_pkg::*;
#(
    parameter int DUTY_BITS = 13
) ();

    logic                  valid;
    logic                  ready;
    logic [DUTY_BITS-1:0]  duty_horiz;
    logic [DUTY_BITS-1:0]  duty_vert;
    logic [ANGLE_BITS-1:0] angle_horiz;
    logic [ANGLE_BITS-1:0] angle_vert;

    modport source (
        output valid,
        output duty_horiz,
        output duty_vert,
        output angle_horiz,
        output angle_vert,
        input  ready
    );

    modport sink (
        input  valid,
        input  duty_horiz,
        input  duty_vert,
        input  angle_horiz,
        input  angle_vert,
        output ready
    );

endinterface

/* src/jsd_ema.sv */
// ----------------------------------------------------------------------------
// jsd_ema: front end, sample intake and exponential smoothing
// Accepts a sample pair, updates both running averages with one shared
// multiplier and pushes the smoothed pair into the queue.
// ----------------------------------------------------------------------------
module jsd_ema
    import jsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    jsd_sample_if.sink                             sample_ch,
    output logic                                   push,
    output logic [2*(SAMPLE_BITS+FRAC_BITS)-1:0]   push_data,
    input  fifo_status_t                           fifo_status
);

    localparam int AVG_BITS  = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_BITS = AVG_BITS + FRAC_BITS;
    localparam int ONE_Q_INT = 2 ** FRAC_BITS;

    localparam logic [FRAC_BITS-1:0] ALPHA_Q = FRAC_BITS'((ONE_Q_INT + 5) / ALPHA_DIV);
    localparam logic [FRAC_BITS-1:0] KEEP_Q  = FRAC_BITS'(ONE_Q_INT - int'(ALPHA_Q));

    // center of the sample range in fixed point
    localparam logic [AVG_BITS-1:0] AVG_RESET = {1'b1, {(AVG_BITS-1){1'b0}}};

    ema_state_t             state_reg, state_next;
    logic                   axis_reg, axis_next;
    logic [SAMPLE_BITS-1:0] samp_h_reg, samp_h_next;
    logic [SAMPLE_BITS-1:0] samp_v_reg, samp_v_next;
    logic [AVG_BITS-1:0]    avg_h_reg, avg_h_next;
    logic [AVG_BITS-1:0]    avg_v_reg, avg_v_next;
    logic [AVG_BITS-1:0]    acc_reg, acc_next;

    logic                   accept;
    logic [FRAC_BITS-1:0]   mul_a;
    logic [AVG_BITS-1:0]    mul_b;
    logic [PROD_BITS-1:0]   product;
    logic [AVG_BITS-1:0]    cur_avg;
    logic [AVG_BITS-1:0]    new_avg;

    // shared multiplier
    assign cur_avg = (axis_reg == AXIS_VERT) ? avg_v_reg : avg_h_reg;
    assign mul_a   = (state_reg == EMA_MUL_SAMPLE) ? ALPHA_Q : KEEP_Q;
    assign mul_b   = (state_reg == EMA_MUL_SAMPLE)
                   ? ((axis_reg == AXIS_VERT) ? AVG_BITS'(samp_v_reg) : AVG_BITS'(samp_h_reg))
                   : cur_avg;
    assign product = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign new_avg = acc_reg + product[FRAC_BITS +: AVG_BITS];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EMA_IDLE:
            begin
                if (sample_ch.valid)
                    state_next = EMA_MUL_SAMPLE;
            end
            EMA_MUL_SAMPLE:
                state_next = EMA_MUL_AVG;
            EMA_MUL_AVG:
            begin
                if (axis_reg == AXIS_VERT)
                    state_next = EMA_PUSH;
                else
                    state_next = EMA_MUL_SAMPLE;
            end
            EMA_PUSH:
            begin
                if (!fifo_status.full)
                    state_next = EMA_IDLE;
            end
            default:
                state_next = EMA_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        sample_ch.ready = (state_reg == EMA_IDLE);
        push            = (state_reg == EMA_PUSH) && !fifo_status.full;
        push_data       = {avg_h_reg, avg_v_reg};
    end

    assign accept = sample_ch.valid && sample_ch.ready;

    // datapath update
    always_comb
    begin
        axis_next   = axis_reg;
        samp_h_next = samp_h_reg;
        samp_v_next = samp_v_reg;
        avg_h_next  = avg_h_reg;
        avg_v_next  = avg_v_reg;
        acc_next    = acc_reg;
        if (accept)
        begin
            samp_h_next = sample_ch.sample_horiz;
            samp_v_next = sample_ch.sample_vert;
            axis_next   = AXIS_HORIZ;
        end
        if (state_reg == EMA_MUL_SAMPLE)
            acc_next = product[AVG_BITS-1:0];
        if (state_reg == EMA_MUL_AVG)
        begin
            if (axis_reg == AXIS_VERT)
                avg_v_next = new_avg;
            else
                avg_h_next = new_avg;
            axis_next = AXIS_VERT;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EMA_IDLE;
            axis_reg  <= AXIS_HORIZ;
            avg_h_reg <= AVG_RESET;
            avg_v_reg <= AVG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            avg_h_reg <= avg_h_next;
            avg_v_reg <= avg_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        samp_h_reg <= samp_h_next;
        samp_v_reg <= samp_v_next;
        acc_reg    <= acc_next;
    end

endmodule

/* src/jsd_fifo.sv */
// ----------------------------------------------------------------------------
// jsd_fifo: short queue between the smoothing front end and the mapper
// Holds smoothed average pairs so either side can stall on its own.
// ----------------------------------------------------------------------------
module jsd_fifo
    import jsd_pkg::*;
#(
    parameter int WIDTH = 56,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_status_t     status
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_BITS'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/jsd_map.sv */
// ----------------------------------------------------------------------------
// jsd_map: back end, deadzone, clamp, piecewise linear map and duty lookup
// Holds the calibration registers, maps each axis off the deadzone and empty
// spans through a five step restoring divider, result in an output register.
// ----------------------------------------------------------------------------
module jsd_map
    import jsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int DUTY_BITS   = 13,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [SAMPLE_BITS-1:0]                 cfg_data,
    output logic                                   pop,
    input  logic [2*(SAMPLE_BITS+FRAC_BITS)-1:0]   pop_data,
    input  fifo_status_t                           fifo_status,
    jsd_duty_if.source                             duty_ch
);

    localparam int AVG_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int NUM_BITS = AVG_BITS + QUOT_BITS;

    localparam logic [SAMPLE_BITS-1:0] CAL_CENTER_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] CAL_MAX_RESET    = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] DEAD_RESET       = SAMPLE_BITS'(DEAD_BAND_RESET);

    typedef logic [DUTY_BITS-1:0] duty_lut_t [LUT_DEPTH];

    // angle to duty table, built at elaboration
    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        longint    pulse;
        for (int a = 0; a < LUT_DEPTH; a++)
        begin
            pulse  = (longint'(a) * (PULSE_MAX_US - PULSE_MIN_US)) / ANGLE_FULL
                   + PULSE_MIN_US;
            lut[a] = DUTY_BITS'((pulse <<< DUTY_BITS) / PERIOD_US);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

    // calibration registers
    logic [SAMPLE_BITS-1:0] x_min_reg, x_center_reg, x_max_reg;
    logic [SAMPLE_BITS-1:0] y_min_reg, y_center_reg, y_max_reg;
    logic [SAMPLE_BITS-1:0] dead_band_reg;

    map_state_t             state_reg, state_next;
    logic                   axis_reg, axis_next;
    logic [AVG_BITS-1:0]    avg_h_reg, avg_h_next;
    logic [AVG_BITS-1:0]    avg_v_reg, avg_v_next;
    logic                   below_reg, below_next;
    logic [AVG_BITS-1:0]    clamp_reg, clamp_next;
    logic [NUM_BITS-1:0]    num_reg, num_next;
    logic [AVG_BITS-1:0]    den_reg, den_next;
    logic [QUOT_BITS-1:0]   quot_reg, quot_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [ANGLE_BITS-1:0]  angle_h_reg, angle_h_next;
    logic [ANGLE_BITS-1:0]  angle_v_reg, angle_v_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DUTY_BITS-1:0]   out_duty_h_reg, out_duty_v_reg;
    logic [ANGLE_BITS-1:0]  out_angle_h_reg, out_angle_v_reg;

    logic                   out_free;
    logic                   load_out;

    logic [AVG_BITS-1:0]    cur_v;
    logic [SAMPLE_BITS-1:0] cal_lo, cal_mid, cal_hi;
    logic [AVG_BITS-1:0]    lo_q, mid_q, hi_q, band_q;
    logic                   below;
    logic [AVG_BITS-1:0]    center_gap;
    logic                   fixed_angle;
    logic [AVG_BITS-1:0]    clamp_val;
    logic [AVG_BITS-1:0]    offs;
    logic [SAMPLE_BITS-1:0] span;
    logic [NUM_BITS-1:0]    den_shift;
    logic                   take;
    logic [QUOT_BITS-1:0]   quot_final;
    logic [ANGLE_BITS-1:0]  angle_div;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg     <= '0;
            x_center_reg  <= CAL_CENTER_RESET;
            x_max_reg     <= CAL_MAX_RESET;
            y_min_reg     <= '0;
            y_center_reg  <= CAL_CENTER_RESET;
            y_max_reg     <= CAL_MAX_RESET;
            dead_band_reg <= DEAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_X_MIN:     x_min_reg     <= cfg_data;
                REG_X_CENTER:  x_center_reg  <= cfg_data;
                REG_X_MAX:     x_max_reg     <= cfg_data;
                REG_Y_MIN:     y_min_reg     <= cfg_data;
                REG_Y_CENTER:  y_center_reg  <= cfg_data;
                REG_Y_MAX:     y_max_reg     <= cfg_data;
                REG_DEAD_BAND: dead_band_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // per axis operand selection
    always_comb
    begin
        if (axis_reg == AXIS_VERT)
        begin
            cur_v   = avg_v_reg;
            cal_lo  = y_min_reg;
            cal_mid = y_center_reg;
            cal_hi  = y_max_reg;
        end
        else
        begin
            cur_v   = avg_h_reg;
            cal_lo  = x_min_reg;
            cal_mid = x_center_reg;
            cal_hi  = x_max_reg;
        end
    end

    assign lo_q   = {cal_lo, {FRAC_BITS{1'b0}}};
    assign mid_q  = {cal_mid, {FRAC_BITS{1'b0}}};
    assign hi_q   = {cal_hi, {FRAC_BITS{1'b0}}};
    assign band_q = {dead_band_reg, {FRAC_BITS{1'b0}}};

    // classification: side, deadzone, empty span, clamp
    assign below       = (cur_v < mid_q);
    assign center_gap  = below ? (mid_q - cur_v) : (cur_v - mid_q);
    assign fixed_angle = (center_gap < band_q)
                      || (below ? (cal_lo >= cal_mid) : (cal_hi <= cal_mid));
    assign clamp_val   = below ? ((cur_v < lo_q) ? lo_q : cur_v)
                               : ((cur_v > hi_q) ? hi_q : cur_v);

    // dividend and divisor setup
    assign offs = below_reg ? (clamp_reg - lo_q) : (clamp_reg - mid_q);
    assign span = below_reg ? (cal_mid - cal_lo) : (cal_hi - cal_mid);

    // one restoring divider step
    assign den_shift  = NUM_BITS'(den_reg) << step_reg;
    assign take       = (num_reg >= den_shift);
    always_comb
    begin
        quot_final = quot_reg;
        if (take)
            quot_final[step_reg] = 1'b1;
    end
    assign angle_div = (below_reg ? ANGLE_LOW : ANGLE_MID) + ANGLE_BITS'(quot_final);

    assign out_free = !out_valid_reg || duty_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MAP_IDLE:
            begin
                if (!fifo_status.empty)
                    state_next = MAP_CLASSIFY;
            end
            MAP_CLASSIFY:
            begin
                if (!fixed_angle)
                    state_next = MAP_PREP;
                else if (axis_reg == AXIS_VERT)
                    state_next = MAP_DONE;
            end
            MAP_PREP:
                state_next = MAP_DIVIDE;
            MAP_DIVIDE:
            begin
                if (step_reg == '0)
                    state_next = (axis_reg == AXIS_VERT) ? MAP_DONE : MAP_CLASSIFY;
            end
            MAP_DONE:
            begin
                if (out_free)
                    state_next = MAP_IDLE;
            end
            default:
                state_next = MAP_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop                 = (state_reg == MAP_IDLE) && !fifo_status.empty;
        load_out            = (state_reg == MAP_DONE) && out_free;
        duty_ch.valid       = out_valid_reg;
        duty_ch.duty_horiz  = out_duty_h_reg;
        duty_ch.duty_vert   = out_duty_v_reg;
        duty_ch.angle_horiz = out_angle_h_reg;
        duty_ch.angle_vert  = out_angle_v_reg;
    end

    // datapath update
    always_comb
    begin
        axis_next      = axis_reg;
        avg_h_next     = avg_h_reg;
        avg_v_next     = avg_v_reg;
        below_next     = below_reg;
        clamp_next     = clamp_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        angle_h_next   = angle_h_reg;
        angle_v_next   = angle_v_reg;
        out_valid_next = out_valid_reg;

        if (duty_ch.valid && duty_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            MAP_IDLE:
            begin
                if (pop)
                begin
                    avg_h_next = pop_data[AVG_BITS +: AVG_BITS];
                    avg_v_next = pop_data[AVG_BITS-1:0];
                    axis_next  = AXIS_HORIZ;
                end
            end
            MAP_CLASSIFY:
            begin
                below_next = below;
                clamp_next = clamp_val;
                if (fixed_angle)
                begin
                    if (axis_reg == AXIS_VERT)
                        angle_v_next = ANGLE_MID;
                    else
                        angle_h_next = ANGLE_MID;
                    axis_next = AXIS_VERT;
                end
            end
            MAP_PREP:
            begin
                num_next  = NUM_BITS'(offs) * NUM_BITS'(ANGLE_STEP);
                den_next  = {span, {FRAC_BITS{1'b0}}};
                quot_next = '0;
                step_next = STEP_BITS'(QUOT_BITS - 1);
            end
            MAP_DIVIDE:
            begin
                if (take)
                    num_next = num_reg - den_shift;
                quot_next = quot_final;
                if (step_reg == '0)
                begin
                    if (axis_reg == AXIS_VERT)
                        angle_v_next = angle_div;
                    else
                        angle_h_next = angle_div;
                    axis_next = AXIS_VERT;
                end
                else
                    step_next = step_reg - 1'b1;
            end
            MAP_DONE:
            begin
                if (load_out)
                    out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= MAP_IDLE;
            axis_reg      <= AXIS_HORIZ;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        avg_h_reg   <= avg_h_next;
        avg_v_reg   <= avg_v_next;
        below_reg   <= below_next;
        clamp_reg   <= clamp_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        quot_reg    <= quot_next;
        angle_h_reg <= angle_h_next;
        angle_v_reg <= angle_v_next;
        if (load_out)
        begin
            out_duty_h_reg  <= DUTY_LUT[angle_h_reg];
            out_duty_v_reg  <= DUTY_LUT[angle_v_reg];
            out_angle_h_reg <= angle_h_reg;
            out_angle_v_reg <= angle_v_reg;
        end
    end

endmodule

/* src/joystick_to_servo_duty.sv */
// ----------------------------------------------------------------------------
// joystick_to_servo_duty: two axis joystick to servo duty mapper
// Smooths each axis, applies the center deadzone and calibration, and turns
// the mapped angle into a servo duty word.
//
//   channel    dir  handshake      payload
//   sample_ch  in   valid/ready    sample_horiz, sample_vert
//   duty_ch    out  valid/ready    duty_horiz, duty_vert, angle_horiz, angle_vert
//   cfg        in   cfg_wr_en      cfg_index, cfg_data (write only)
//
// The front end accepts a sample pair, makes four passes through its shared
// multiplier and pushes the pair, waiting while the queue is full; it takes
// no new sample before the push. The mapper pops a pair, handles each axis with
// only a classify step in the deadzone or on an empty span, else classify,
// prepare and the five step divider, and loads the output register when free.
// Reset restores the calibration defaults and centers both averages.
// A queue of QUEUE_DEPTH entries and the output register let either side stall.
// ----------------------------------------------------------------------------
module joystick_to_servo_duty
    import jsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int DUTY_BITS   = 13,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    jsd_sample_if.sink                sample_ch,
    jsd_duty_if.source                duty_ch,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]    cfg_data
);

    localparam int PAIR_BITS = 2 * (SAMPLE_BITS + FRAC_BITS);

    logic                 push;
    logic [PAIR_BITS-1:0] push_data;
    logic                 pop;
    logic [PAIR_BITS-1:0] pop_data;
    fifo_status_t         fifo_status;

    // smoothing front end
    jsd_ema #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ema (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .push        (push),
        .push_data   (push_data),
        .fifo_status (fifo_status)
    );

    // queue of smoothed pairs
    jsd_fifo #(
        .WIDTH (PAIR_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_status)
    );

    // mapping back end
    jsd_map #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DUTY_BITS   (DUTY_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pop         (pop),
        .pop_data    (pop_data),
        .fifo_status (fifo_status),
        .duty_ch     (duty_ch)
    );

endmodule
